// ===== hdl/lcdw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_pkg: shared types, codes and microcode for the character LCD writer
// Control word layout, step codes, command constants and the program ROM.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int LINE_LENGTH = 16;
  localparam int POS_W       = $clog2(LINE_LENGTH + 1);
  localparam int STEP_W      = 5;
  localparam int LINE_STRIDE = 40;

  localparam logic [POS_W-1:0] LINE_LEN_POS  = POS_W'(LINE_LENGTH);
  localparam logic [POS_W-1:0] LINE_LAST_POS = POS_W'(LINE_LENGTH - 1);

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_PUT  = 2'd1;
  localparam logic [1:0] REQ_EOL  = 2'd2;
  localparam logic [1:0] REQ_RAW  = 2'd3;

  localparam logic [3:0] NIB_WAKE      = 4'b0011;
  localparam logic [3:0] NIB_FOUR_BIT  = 4'b0010;
  localparam logic [7:0] CMD_FUNC_SET  = 8'b0010_0000 | 8'b0000_1000;
  localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
  localparam logic [7:0] CMD_DISP_ON   = 8'b0000_1000 | 8'b0000_0100 | 8'b0000_0011;
  localparam logic [7:0] CMD_ENTRY     = 8'b0000_0100 | 8'b0000_0010;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] LINE_ADDR_0   = 8'h80;
  localparam logic [7:0] LINE_ADDR_1   = 8'h80 | (8'(LINE_STRIDE) & 8'h7f);

  localparam logic [2:0] NSEL_CONST   = 3'd0;
  localparam logic [2:0] NSEL_DATA_HI = 3'd1;
  localparam logic [2:0] NSEL_DATA_LO = 3'd2;
  localparam logic [2:0] NSEL_ADDR_HI = 3'd3;
  localparam logic [2:0] NSEL_ADDR_LO = 3'd4;

  localparam logic [1:0] RSEL_CMD  = 2'd0;
  localparam logic [1:0] RSEL_DATA = 2'd1;
  localparam logic [1:0] RSEL_RAW  = 2'd2;

  localparam logic [1:0] LAST_NO   = 2'd0;
  localparam logic [1:0] LAST_YES  = 2'd1;
  localparam logic [1:0] LAST_FILL = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_OPEN  = 3'd2;
  localparam logic [2:0] ACT_INC   = 3'd3;
  localparam logic [2:0] ACT_CLOSE = 3'd4;

  localparam logic [2:0] COND_NEXT    = 3'd0;
  localparam logic [2:0] COND_END     = 3'd1;
  localparam logic [2:0] COND_IF_OPEN = 3'd2;
  localparam logic [2:0] COND_IF_FULL = 3'd3;
  localparam logic [2:0] COND_GOTO    = 3'd4;

  localparam logic [STEP_W-1:0] ENTRY_INIT     = 5'd0;
  localparam logic [STEP_W-1:0] ENTRY_PUT      = 5'd12;
  localparam logic [STEP_W-1:0] STEP_PUT_CHAR  = 5'd15;
  localparam logic [STEP_W-1:0] ENTRY_EOL      = 5'd17;
  localparam logic [STEP_W-1:0] STEP_EOL_CLOSE = 5'd20;
  localparam logic [STEP_W-1:0] ENTRY_RAW      = 5'd21;

  typedef struct packed {
    logic              emit;
    logic [2:0]        nsel;
    logic [3:0]        konst;
    logic [1:0]        rsel;
    logic              lw;
    logic [1:0]        lastm;
    logic [2:0]        act;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } lcdw_cw_t;

  typedef struct packed {
    logic is_open;
    logic full;
  } lcdw_flags_t;

  typedef struct packed {
    logic     busy;
    logic     fire;
    lcdw_cw_t cw;
  } lcdw_ctl_t;

  function automatic lcdw_cw_t cw_emit(input logic [2:0] nsel, input logic [3:0] konst,
                                       input logic [1:0] rsel, input logic lw,
                                       input logic [1:0] lastm, input logic [2:0] act,
                                       input logic [2:0] cond,
                                       input logic [STEP_W-1:0] target);
    return '{emit: 1'b1, nsel: nsel, konst: konst, rsel: rsel, lw: lw, lastm: lastm,
             act: act, cond: cond, target: target};
  endfunction

  function automatic lcdw_cw_t cw_ctl(input logic [2:0] act, input logic [2:0] cond,
                                      input logic [STEP_W-1:0] target);
    return '{emit: 1'b0, nsel: NSEL_CONST, konst: 4'd0, rsel: RSEL_CMD, lw: 1'b0,
             lastm: LAST_NO, act: act, cond: cond, target: target};
  endfunction

  function automatic logic [STEP_W-1:0] entry_of(input logic [1:0] req_type);
    case (req_type)
      REQ_INIT: return ENTRY_INIT;
      REQ_PUT:  return ENTRY_PUT;
      REQ_EOL:  return ENTRY_EOL;
      default:  return ENTRY_RAW;
    endcase
  endfunction

  function automatic lcdw_cw_t ucode(input logic [STEP_W-1:0] step);
    case (step)
      5'd0:  return cw_emit(NSEL_CONST, NIB_WAKE, RSEL_CMD, 1'b1, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd1:  return cw_emit(NSEL_CONST, NIB_WAKE, RSEL_CMD, 1'b1, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd2:  return cw_emit(NSEL_CONST, NIB_WAKE, RSEL_CMD, 1'b1, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd3:  return cw_emit(NSEL_CONST, NIB_FOUR_BIT, RSEL_CMD, 1'b1, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd4:  return cw_emit(NSEL_CONST, CMD_FUNC_SET[7:4], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd5:  return cw_emit(NSEL_CONST, CMD_FUNC_SET[3:0], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd6:  return cw_emit(NSEL_CONST, CMD_CLEAR[7:4], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd7:  return cw_emit(NSEL_CONST, CMD_CLEAR[3:0], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd8:  return cw_emit(NSEL_CONST, CMD_DISP_ON[7:4], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd9:  return cw_emit(NSEL_CONST, CMD_DISP_ON[3:0], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd10: return cw_emit(NSEL_CONST, CMD_ENTRY[7:4], RSEL_CMD, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd11: return cw_emit(NSEL_CONST, CMD_ENTRY[3:0], RSEL_CMD, 1'b0, LAST_YES,
                            ACT_CLEAR, COND_END, '0);
      5'd12: return cw_ctl(ACT_NONE, COND_IF_OPEN, STEP_PUT_CHAR);
      5'd13: return cw_emit(NSEL_ADDR_HI, 4'd0, RSEL_CMD, 1'b0, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd14: return cw_emit(NSEL_ADDR_LO, 4'd0, RSEL_CMD, 1'b1, LAST_NO, ACT_OPEN,
                            COND_NEXT, '0);
      5'd15: return cw_emit(NSEL_DATA_HI, 4'd0, RSEL_DATA, 1'b0, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd16: return cw_emit(NSEL_DATA_LO, 4'd0, RSEL_DATA, 1'b0, LAST_YES, ACT_INC,
                            COND_END, '0);
      5'd17: return cw_ctl(ACT_NONE, COND_IF_FULL, STEP_EOL_CLOSE);
      5'd18: return cw_emit(NSEL_CONST, CHAR_SPACE[7:4], RSEL_DATA, 1'b0, LAST_NO,
                            ACT_NONE, COND_NEXT, '0);
      5'd19: return cw_emit(NSEL_CONST, CHAR_SPACE[3:0], RSEL_DATA, 1'b0, LAST_FILL,
                            ACT_INC, COND_GOTO, ENTRY_EOL);
      5'd20: return cw_ctl(ACT_CLOSE, COND_END, '0);
      5'd21: return cw_emit(NSEL_DATA_HI, 4'd0, RSEL_RAW, 1'b0, LAST_NO, ACT_NONE,
                            COND_NEXT, '0);
      5'd22: return cw_emit(NSEL_DATA_LO, 4'd0, RSEL_RAW, 1'b0, LAST_YES, ACT_NONE,
                            COND_END, '0);
      default: return cw_ctl(ACT_NONE, COND_END, '0);
    endcase
  endfunction

endpackage

// ===== hdl/lcdw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_if: request and nibble channels of the character LCD writer
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lcdw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       line;
  logic [7:0] data;
  logic       register_select;

  modport source (output valid, output req_type, output line, output data,
                  output register_select, input ready);
  modport sink (input valid, input req_type, input line, input data,
                input register_select, output ready);
endinterface

interface lcdw_nib_if;
  logic       valid;
  logic       ready;
  logic       pin_register_select;
  logic [3:0] nibble;
  logic       long_wait;
  logic       last;

  modport source (output valid, output pin_register_select, output nibble,
                  output long_wait, output last, input ready);
  modport sink (input valid, input pin_register_select, input nibble,
                input long_wait, input last, output ready);
endinterface

// ===== hdl/lcdw_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdw_seq: microcode sequencer
// Step counter over the program ROM with conditional jumps on line state.
// ----------------------------------------------------------------------------
module lcdw_seq import lcdw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  req_type,
  input  logic        stall,
  input  lcdw_flags_t flags,
  output lcdw_ctl_t   ctl
);

  logic              busy;
  logic [STEP_W-1:0] step;
  lcdw_cw_t          cw;
  logic              fire;

  assign cw   = ucode(step);
  assign fire = busy && !(cw.emit && stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= entry_of(req_type);
    end else if (fire) begin
      case (cw.cond)
        COND_NEXT: step <= step + 1'b1;
        COND_END: busy <= 1'b0;
        COND_IF_OPEN: step <= flags.is_open ? cw.target : step + 1'b1;
        COND_IF_FULL: step <= flags.full ? cw.target : step + 1'b1;
        COND_GOTO: step <= cw.target;
        default: busy <= 1'b0;
      endcase
    end
  end

  assign ctl = '{busy: busy, fire: fire, cw: cw};

endmodule

// ===== hdl/char_lcd_nibble_line_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_line_writer: character LCD request to 4-bit nibble writer
// The first nibble comes from the first step for init and raw write; put and
// end of line start with a control step on the line state.
// Throughput: one request at a time, one microcode step per cycle; a nibble
// step waits while the output register holds a word not yet taken. Init takes
// 12 steps, put 3 or 5, raw write 2, end of line 2 plus 3 per space; the next
// request is taken the cycle after the final step.
// Reset clears the sequencer, the output valid flag and both lines' state.
// ----------------------------------------------------------------------------
module char_lcd_nibble_line_writer import lcdw_pkg::*; (
  input  logic clk,
  input  logic rst,
  lcdw_req_if.sink   req,
  lcdw_nib_if.source nib
);

  lcdw_ctl_t   ctl;
  lcdw_flags_t flags;
  logic        accept;
  logic        stall;

  logic             line_sel;
  logic [7:0]       data_reg;
  logic             rsel_reg;
  logic             line_open [2];
  logic [POS_W-1:0] line_pos [2];
  logic [POS_W-1:0] pos_cur;
  logic [7:0]       addr;

  logic       out_valid;
  logic       out_rs;
  logic [3:0] out_nibble;
  logic       out_lw;
  logic       out_last;

  logic       nib_next;
  logic       rs_next;
  logic       last_next;
  logic [3:0] nib_val;

  assign accept    = req.valid && req.ready;
  assign req.ready = !ctl.busy;
  assign stall     = out_valid && !nib.ready;

  assign pos_cur       = line_pos[line_sel];
  assign flags.is_open = line_open[line_sel];
  assign flags.full    = !line_open[line_sel] || (pos_cur >= LINE_LEN_POS);
  assign addr          = line_sel ? LINE_ADDR_1 : LINE_ADDR_0;

  lcdw_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .req_type (req.req_type),
    .stall    (stall),
    .flags    (flags),
    .ctl      (ctl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      line_sel <= req.line;
      data_reg <= req.data;
      rsel_reg <= req.register_select;
    end
  end

  always_comb begin
    case (ctl.cw.nsel)
      NSEL_DATA_HI: nib_val = data_reg[7:4];
      NSEL_DATA_LO: nib_val = data_reg[3:0];
      NSEL_ADDR_HI: nib_val = addr[7:4];
      NSEL_ADDR_LO: nib_val = addr[3:0];
      default:      nib_val = ctl.cw.konst;
    endcase
    case (ctl.cw.rsel)
      RSEL_DATA: rs_next = 1'b1;
      RSEL_RAW:  rs_next = rsel_reg;
      default:   rs_next = 1'b0;
    endcase
    case (ctl.cw.lastm)
      LAST_YES:  last_next = 1'b1;
      LAST_FILL: last_next = (pos_cur == LINE_LAST_POS);
      default:   last_next = 1'b0;
    endcase
  end

  assign nib_next = ctl.fire && ctl.cw.emit;

  // Line state updates on each completed step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        line_open[i] <= 1'b0;
        line_pos[i]  <= '0;
      end
    end else if (ctl.fire) begin
      case (ctl.cw.act)
        ACT_CLEAR: begin
          for (int i = 0; i < 2; i++) begin
            line_open[i] <= 1'b0;
            line_pos[i]  <= '0;
          end
        end
        ACT_OPEN: begin
          line_open[line_sel] <= 1'b1;
          line_pos[line_sel]  <= '0;
        end
        ACT_INC: begin
          if (pos_cur < LINE_LEN_POS) begin
            line_pos[line_sel] <= pos_cur + 1'b1;
          end
        end
        ACT_CLOSE: line_open[line_sel] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Output register: load a word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (nib_next) begin
      out_valid <= 1'b1;
    end else if (nib.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (nib_next) begin
      out_rs     <= rs_next;
      out_nibble <= nib_val;
      out_lw     <= ctl.cw.lw;
      out_last   <= last_next;
    end
  end

  assign nib.valid               = out_valid;
  assign nib.pin_register_select = out_rs;
  assign nib.nibble              = out_nibble;
  assign nib.long_wait           = out_lw;
  assign nib.last                = out_last;

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (line_pos[0] <= LINE_LEN_POS) && (line_pos[1] <= LINE_LEN_POS))
    else $error("line position past line length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    nib_next |-> (!out_valid || nib.ready))
    else $error("nibble loaded over a word not yet taken");

  a_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.busy))
    else $error("nibble produced while sequencer idle");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (ctl.busy && !$past(ctl.busy)))
    else $error("request taken while sequencer busy");
`endif

endmodule
